// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MWMM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("mwmm assertion failed");

// Check a property on every clock edge, reset included.
`define MWMM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("mwmm reset assertion failed");

`endif

// ----- rtl/mwmm_pkg.sv -----
package mwmm_pkg;

    // Operation codes of an input transaction
    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    // One stored map entry
    typedef struct packed {
        logic [3:0] known;
        logic       seen;
        logic [3:0] wall;
    } t_cell_ent;

    // Width for coordinate compares against the grid size
    localparam int CMP_W = 6;

    // Raw wall bit of the neighbour that faces each side (N, E, S, W)
    localparam logic [1:0] OPP_BIT [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

    // Reverse a nibble: raw bit3 north ... bit0 west into bit0 north ... bit3 west
    function automatic logic [3:0] flip4(input logic [3:0] v);
        flip4 = {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

// ----- rtl/maze_wall_map_merge.sv -----
// A cell is registered in stage one, then its result in the output register.
// Throughput: one cell per cycle unless the output stalls or a clear pass runs;
// the single map memory does one read and one write each cycle, and a
// back-to-back access to the same cell is forwarded. Reset (synchronous, active
// low) and the clear opcode both start a pass that zeroes the map memory with o_ready held low.
module maze_wall_map_merge import mwmm_pkg::*; #(
    parameter int GRID_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [0:0]  i_opcode,
    input  logic [3:0]  i_cell_x,
    input  logic [3:0]  i_cell_y,
    input  logic [7:0]  i_cell_raw,
    input  logic [7:0]  i_north_raw,
    input  logic [7:0]  i_east_raw,
    input  logic [7:0]  i_south_raw,
    input  logic [7:0]  i_west_raw,
    input  logic        i_cell_visited,
    input  logic        i_last_cell,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_known_dirs,
    output logic [3:0]  o_wall_dirs,
    output logic        o_conflict,
    output logic        o_pass_done,
    output logic        o_pass_ok,
    output logic        o_map_changed,
    output logic [31:0] o_generation_count,
    output logic [31:0] o_epoch_count
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int EW    = $bits(t_cell_ent);

    // Stage one contents
    typedef struct packed {
        t_op          op;
        logic         last;
        logic         visited;
        logic         in_grid;
        logic         bad;
        logic [AW-1:0] addr;
        logic [3:0]   known;
        logic [3:0]   wall;
    } t_s1;

    logic          in_fire, s1_fire, s1_wr;
    logic          r_s1_valid, n_s1_valid;
    t_s1           r_s1, n_s1;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_cell_ent     r_fwd_data;

    logic          r_pass_changed, r_pass_corrected, r_pass_aborted;
    logic          n_pass_changed, n_pass_corrected, n_pass_aborted;
    logic [31:0]   r_gen, n_gen, r_epoch, n_epoch;

    logic          r_o_valid;
    logic [3:0]    r_known_dirs, n_known_dirs, r_wall_dirs, n_wall_dirs;
    logic          r_conflict, n_conflict, r_pass_done, n_pass_done;
    logic          r_pass_ok, n_pass_ok, r_map_changed, n_map_changed;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_cell_ent     ram_wdata, ram_rdata, cur;
    logic [EW-1:0] ram_rdata_bits;

    // Neighbor bytes and derived side values of the incoming cell
    logic [7:0]       nb [4];
    logic [CMP_W-1:0] xw, yw, gw;
    logic [3:0]       side_edge, k0, w0, kf, wf, bad_d;
    logic [1:0]       ob;
    logic             oknown, owall;

    assign in_fire = i_valid & o_ready;
    assign s1_fire = r_s1_valid & (~r_o_valid | i_ready);
    assign o_ready = ~r_clr_busy & ~(r_s1_valid & (r_s1.op == OP_CLEAR))
                   & (~r_s1_valid | s1_fire);

    assign nb[0] = i_north_raw;
    assign nb[1] = i_east_raw;
    assign nb[2] = i_south_raw;
    assign nb[3] = i_west_raw;
    assign xw = CMP_W'(i_cell_x);
    assign yw = CMP_W'(i_cell_y);
    assign gw = CMP_W'(GRID_SIZE);

    // Mark grid edges
    always_comb begin
        side_edge[0] = (yw + CMP_W'(1)) >= gw;
        side_edge[1] = (xw + CMP_W'(1)) >= gw;
        side_edge[2] = (i_cell_y == 4'd0) || (yw >= gw);
        side_edge[3] = (i_cell_x == 4'd0) || (xw >= gw);
    end

    // Merge each side with the facing side of its neighbor
    always_comb begin
        k0 = flip4(~(i_cell_raw[7:4] ^ i_cell_raw[3:0]));
        w0 = flip4(i_cell_raw[3:0]);
        for (int d = 0; d < 4; d++) begin
            ob       = OPP_BIT[d];
            oknown   = ~(nb[d][ob] ^ nb[d][{1'b1, ob}]);
            owall    = nb[d][ob];
            bad_d[d] = ~side_edge[d] & oknown & k0[d] & (owall ^ w0[d]);
            kf[d]    = side_edge[d] | k0[d] | oknown;
            wf[d]    = side_edge[d] | (oknown ? owall : w0[d]);
        end
    end

    // Load stage one
    always_comb begin
        n_s1.op      = t_op'(i_opcode);
        n_s1.last    = i_last_cell;
        n_s1.visited = i_cell_visited;
        n_s1.in_grid = (xw < gw) && (yw < gw);
        n_s1.bad     = |bad_d;
        n_s1.addr    = AW'(int'(i_cell_y) * GRID_SIZE + int'(i_cell_x));
        n_s1.known   = kf;
        n_s1.wall    = wf;
        n_s1_valid   = in_fire | (r_s1_valid & ~s1_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
    end

    // Map memory: clearing pass or cell write-back
    assign s1_wr = s1_fire & (r_s1.op == OP_CELL) & ~r_pass_aborted & ~r_s1.bad
                 & r_s1.in_grid;
    assign ram_we    = r_clr_busy | s1_wr;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1.addr;
    always_comb begin
        ram_wdata.known = r_clr_busy ? 4'd0 : r_s1.known;
        ram_wdata.wall  = r_clr_busy ? 4'd0 : r_s1.wall;
        ram_wdata.seen  = r_clr_busy ? 1'b0 : r_s1.visited;
    end

    mwmm_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (n_s1.addr),
        .o_rdata (ram_rdata_bits)
    );
    assign ram_rdata = t_cell_ent'(ram_rdata_bits);

    // Forward the last write over a read that raced it
    assign cur = (r_fwd_valid && (r_fwd_addr == r_s1.addr)) ? r_fwd_data : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_fire && (r_s1.op == OP_CLEAR)) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_wr) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_fwd_addr <= r_s1.addr;
            r_fwd_data <= ram_wdata;
        end
    end

    // Sweep the memory to zero after reset and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end else if (s1_fire && (r_s1.op == OP_CLEAR)) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    // Compare with stored entry, update pass flags and counters
    always_comb begin
        logic [1:0] ep_inc;
        ep_inc           = 2'd0;
        n_pass_changed   = r_pass_changed;
        n_pass_corrected = r_pass_corrected;
        n_pass_aborted   = r_pass_aborted;
        n_gen            = r_gen;
        n_epoch          = r_epoch;
        n_known_dirs     = 4'd0;
        n_wall_dirs      = 4'd0;
        n_conflict       = 1'b0;
        n_pass_done      = 1'b0;
        n_pass_ok        = 1'b0;
        n_map_changed    = 1'b0;
        if (r_s1.op == OP_CLEAR) begin
            n_pass_changed   = 1'b0;
            n_pass_corrected = 1'b0;
            n_pass_aborted   = 1'b0;
            n_gen            = 32'd0;
            n_epoch          = 32'd1;
        end else begin
            if (!r_pass_aborted) begin
                if (r_s1.bad) begin
                    n_pass_aborted = 1'b1;
                    n_conflict     = 1'b1;
                end else begin
                    n_known_dirs = r_s1.known;
                    n_wall_dirs  = r_s1.wall;
                    if (r_s1.in_grid) begin
                        if (((cur.known & ~r_s1.known) != 4'd0)
                            || (((cur.wall ^ r_s1.wall) & cur.known) != 4'd0)
                            || (cur.seen && !r_s1.visited)) begin
                            n_pass_corrected = 1'b1;
                        end
                        if ((cur.known != r_s1.known) || (cur.wall != r_s1.wall)
                            || (cur.seen != r_s1.visited)) begin
                            n_pass_changed = 1'b1;
                        end
                    end
                end
            end
            if (r_s1.last) begin
                n_pass_done   = 1'b1;
                n_pass_ok     = ~n_pass_aborted;
                n_map_changed = n_pass_changed;
                if (!n_pass_aborted) begin
                    ep_inc = {1'b0, n_pass_corrected};
                    if (n_pass_changed) begin
                        if (r_gen == 32'hFFFF_FFFF) begin
                            ep_inc = ep_inc + 2'd1;
                            n_gen  = 32'd1;
                        end else begin
                            n_gen = r_gen + 32'd1;
                        end
                    end
                    n_epoch = r_epoch + 32'(ep_inc);
                end
                n_pass_changed   = 1'b0;
                n_pass_corrected = 1'b0;
                n_pass_aborted   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_changed   <= 1'b0;
            r_pass_corrected <= 1'b0;
            r_pass_aborted   <= 1'b0;
            r_gen            <= 32'd0;
            r_epoch          <= 32'd1;
        end else if (s1_fire) begin
            r_pass_changed   <= n_pass_changed;
            r_pass_corrected <= n_pass_corrected;
            r_pass_aborted   <= n_pass_aborted;
            r_gen            <= n_gen;
            r_epoch          <= n_epoch;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= s1_fire | (r_o_valid & ~i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_known_dirs  <= n_known_dirs;
            r_wall_dirs   <= n_wall_dirs;
            r_conflict    <= n_conflict;
            r_pass_done   <= n_pass_done;
            r_pass_ok     <= n_pass_ok;
            r_map_changed <= n_map_changed;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_known_dirs       = r_known_dirs;
    assign o_wall_dirs        = r_wall_dirs;
    assign o_conflict         = r_conflict;
    assign o_pass_done        = r_pass_done;
    assign o_pass_ok          = r_pass_ok;
    assign o_map_changed      = r_map_changed;
    assign o_generation_count = r_gen;
    assign o_epoch_count      = r_epoch;

endmodule

// ----- rtl/mwmm_ram.sv -----
module mwmm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mwmm_chk.sv -----
`include "assert_macros.svh"

module mwmm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [0:0]  i_opcode,
    input logic [3:0]  i_cell_x,
    input logic [3:0]  i_cell_y,
    input logic [7:0]  i_cell_raw,
    input logic [7:0]  i_north_raw,
    input logic [7:0]  i_east_raw,
    input logic [7:0]  i_south_raw,
    input logic [7:0]  i_west_raw,
    input logic        i_cell_visited,
    input logic        i_last_cell,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_known_dirs,
    input logic [3:0]  o_wall_dirs,
    input logic        o_conflict,
    input logic        o_pass_done,
    input logic        o_pass_ok,
    input logic        o_map_changed,
    input logic [31:0] o_generation_count,
    input logic [31:0] o_epoch_count
);

    // A stalled result transaction holds its counters
    `MWMM_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_generation_count) && $stable(o_epoch_count))

    // A conflicting cell reports no sides
    `MWMM_ASSERT(a_conflict_zero, o_valid && o_conflict |-> o_known_dirs == 4'd0 && o_wall_dirs == 4'd0)

    // Pass summary flags only show at the end of a pass
    `MWMM_ASSERT(a_summary_end, o_valid && !o_pass_done |-> !o_pass_ok && !o_map_changed)

    // Reset drops the result and input handshakes
    `MWMM_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_valid && !o_ready)

endmodule

bind maze_wall_map_merge mwmm_chk u_mwmm_chk (.*);

// ----- tb/sv/tb_maze_wall_map_merge.sv -----
`timescale 1ns / 100ps

module tb_maze_wall_map_merge;
    import mwmm_pkg::*;

    localparam int GRID = 16;
    localparam int CELLS = GRID * GRID;
    localparam int RANDOM_CELLS = 1550;

    // One input transaction; nb is indexed north, east, south, west
    typedef struct packed {
        t_op             op;
        logic [3:0]      x;
        logic [3:0]      y;
        logic [7:0]      raw;
        logic [3:0][7:0] nb;
        logic            visited;
        logic            last;
    } t_cell_txn;

    // One merged result
    typedef struct packed {
        logic [3:0]  known;
        logic [3:0]  wall;
        logic        conflict;
        logic        done;
        logic        ok;
        logic        changed;
        logic [31:0] gen;
        logic [31:0] epoch;
    } t_merge_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [0:0]  i_opcode;
    logic [3:0]  i_cell_x;
    logic [3:0]  i_cell_y;
    logic [7:0]  i_cell_raw;
    logic [7:0]  i_north_raw;
    logic [7:0]  i_east_raw;
    logic [7:0]  i_south_raw;
    logic [7:0]  i_west_raw;
    logic        i_cell_visited;
    logic        i_last_cell;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_known_dirs;
    logic [3:0]  o_wall_dirs;
    logic        o_conflict;
    logic        o_pass_done;
    logic        o_pass_ok;
    logic        o_map_changed;
    logic [31:0] o_generation_count;
    logic [31:0] o_epoch_count;

    t_cell_txn   cur_txn = '0;
    t_cell_txn   cell_q[$];
    t_merge_res  merge_q[$];
    int          err_count = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    // Predicted map and pass state
    logic [3:0]  map_known [CELLS];
    logic [3:0]  map_wall [CELLS];
    logic        map_seen [CELLS];
    logic        pass_chg;
    logic        pass_fix;
    logic        pass_abort;
    logic [31:0] gen_q;
    logic [31:0] epoch_q;

    // Maze used to build consistent cell bytes: wall north of and east of (x, y)
    logic        maze_n [GRID][GRID];
    logic        maze_e [GRID][GRID];
    logic        robot_seen [GRID][GRID];

    assign i_opcode       = cur_txn.op;
    assign i_cell_x       = cur_txn.x;
    assign i_cell_y       = cur_txn.y;
    assign i_cell_raw     = cur_txn.raw;
    assign i_north_raw    = cur_txn.nb[0];
    assign i_east_raw     = cur_txn.nb[1];
    assign i_south_raw    = cur_txn.nb[2];
    assign i_west_raw     = cur_txn.nb[3];
    assign i_cell_visited = cur_txn.visited;
    assign i_last_cell    = cur_txn.last;

    maze_wall_map_merge dut (.*);

    always #5 i_clk = ~i_clk;

    // Reverse a nibble so raw bit3 lands on north
    function automatic logic [3:0] rev_nib(input logic [3:0] v);
        logic [3:0] r;
        for (int i = 0; i < 4; i++) r[i] = v[3 - i];
        return r;
    endfunction

    function automatic void clear_map();
        for (int i = 0; i < CELLS; i++) begin
            map_known[i] = '0;
            map_wall[i]  = '0;
            map_seen[i]  = 1'b0;
        end
        pass_chg   = 1'b0;
        pass_fix   = 1'b0;
        pass_abort = 1'b0;
        gen_q      = '0;
        epoch_q    = 32'd1;
    endfunction

    // Merge one cell into the predicted map and return the expected result
    function automatic t_merge_res merge_cell(input t_cell_txn t);
        t_merge_res r;
        logic [3:0] k, w, b;
        logic [7:0] other;
        logic       bad, at_edge, nb_known, nb_wall;
        int         ob, c;
        r = '0;
        if (t.op == OP_CLEAR) begin
            clear_map();
        end else begin
            if (!pass_abort) begin
                k = rev_nib(~(t.raw[7:4] ^ t.raw[3:0]));
                w = rev_nib(t.raw[3:0]);
                bad = 1'b0;
                for (int d = 0; d < 4; d++) begin
                    if (!bad) begin
                        b = 4'b0001 << d;
                        case (d)
                            0: at_edge = int'(t.y) + 1 >= GRID;
                            1: at_edge = int'(t.x) + 1 >= GRID;
                            2: at_edge = (t.y == 0) || int'(t.y) >= GRID;
                            default: at_edge = (t.x == 0) || int'(t.x) >= GRID;
                        endcase
                        if (at_edge) begin
                            k |= b;
                            w |= b;
                        end else begin
                            // neighbor side that faces this cell
                            other    = t.nb[d];
                            ob       = 3 - ((d + 2) % 4);
                            nb_known = other[ob] == other[ob + 4];
                            nb_wall  = other[ob];
                            if (nb_known && (k & b) != 0 && nb_wall != ((w & b) != 0)) begin
                                bad = 1'b1;
                            end else if (nb_known) begin
                                k |= b;
                                if (nb_wall) w |= b;
                                else w &= ~b;
                            end
                        end
                    end
                end
                if (bad) begin
                    pass_abort = 1'b1;
                    r.conflict = 1'b1;
                end else begin
                    r.known = k;
                    r.wall  = w;
                    if (int'(t.x) < GRID && int'(t.y) < GRID) begin
                        c = int'(t.y) * GRID + int'(t.x);
                        if ((map_known[c] & ~k) != 0 ||
                            ((map_wall[c] ^ w) & map_known[c]) != 0)
                            pass_fix = 1'b1;
                        if (map_known[c] != k || map_wall[c] != w ||
                            map_seen[c] != t.visited)
                            pass_chg = 1'b1;
                        if (map_seen[c] && !t.visited) pass_fix = 1'b1;
                        map_known[c] = k;
                        map_wall[c]  = w;
                        map_seen[c]  = t.visited;
                    end
                end
            end
            // Close the pass and advance the counters
            if (t.last) begin
                r.done    = 1'b1;
                r.ok      = !pass_abort;
                r.changed = pass_chg;
                if (!pass_abort) begin
                    if (pass_fix) epoch_q = epoch_q + 1;
                    if (pass_chg) begin
                        if (gen_q == '1) begin
                            epoch_q = epoch_q + 1;
                            gen_q   = '0;
                        end
                        gen_q = gen_q + 1;
                    end
                end
                pass_chg   = 1'b0;
                pass_fix   = 1'b0;
                pass_abort = 1'b0;
            end
        end
        r.gen   = gen_q;
        r.epoch = epoch_q;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none in a burst
    function automatic int pick_gap(input bit burst);
        int p;
        p = $urandom_range(0, 99);
        if (burst || p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Raw byte of cell (x, y) from the maze, with unknown sides and noise
    function automatic logic [7:0] side_byte(input int x, input int y,
                                             input int known_pct, input int noise_pct);
        logic [3:0] lo, hi;
        lo[3] = (y < GRID - 1) ? maze_n[x][y] : 1'($urandom);
        lo[2] = (x < GRID - 1) ? maze_e[x][y] : 1'($urandom);
        lo[1] = (y > 0) ? maze_n[x][y - 1] : 1'($urandom);
        lo[0] = (x > 0) ? maze_e[x - 1][y] : 1'($urandom);
        for (int s = 0; s < 4; s++) begin
            if ($urandom_range(0, 99) < noise_pct) lo[s] = ~lo[s];
            hi[s] = ($urandom_range(0, 99) < known_pct) ? lo[s] : ~lo[s];
        end
        return {hi, lo};
    endfunction

    task automatic add_item(input t_op op, input int x, input int y, input logic [7:0] raw,
                            input logic [7:0] nbyte, input bit visited, input bit last);
        t_cell_txn t;
        t.op      = op;
        t.x       = 4'(x);
        t.y       = 4'(y);
        t.raw     = raw;
        t.nb      = {4{nbyte}};
        t.visited = visited;
        t.last    = last;
        cell_q.push_back(t);
    endtask

    // Queue a row-order scan over a rectangle, ending the pass on its last cell
    task automatic add_pass(input int x0, input int y0, input int w, input int h,
                            input int known_pct, input int noise_pct);
        t_cell_txn t;
        for (int y = y0; y < y0 + h; y++) begin
            for (int x = x0; x < x0 + w; x++) begin
                if ($urandom_range(0, 19) == 0) robot_seen[x][y] = !robot_seen[x][y];
                t.op      = OP_CELL;
                t.x       = 4'(x);
                t.y       = 4'(y);
                t.raw     = side_byte(x, y, known_pct, noise_pct);
                t.nb[0]   = (y < GRID - 1) ? side_byte(x, y + 1, known_pct, noise_pct)
                                           : 8'($urandom);
                t.nb[1]   = (x < GRID - 1) ? side_byte(x + 1, y, known_pct, noise_pct)
                                           : 8'($urandom);
                t.nb[2]   = (y > 0) ? side_byte(x, y - 1, known_pct, noise_pct)
                                    : 8'($urandom);
                t.nb[3]   = (x > 0) ? side_byte(x - 1, y, known_pct, noise_pct)
                                    : 8'($urandom);
                t.visited = robot_seen[x][y];
                t.last    = (x == x0 + w - 1) && (y == y0 + h - 1);
                cell_q.push_back(t);
            end
        end
    endtask

    task automatic flag_error(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_merge();
        t_merge_res got, want;
        got = {o_known_dirs, o_wall_dirs, o_conflict, o_pass_done, o_pass_ok,
               o_map_changed, o_generation_count, o_epoch_count};
        if (merge_q.size() == 0) begin
            flag_error("result transaction with nothing expected");
        end else begin
            want = merge_q.pop_front();
            if (got.known != want.known)
                flag_error($sformatf("known_dirs %h, expected %h", got.known, want.known));
            if (got.wall != want.wall)
                flag_error($sformatf("wall_dirs %h, expected %h", got.wall, want.wall));
            if (got.conflict != want.conflict)
                flag_error($sformatf("conflict %b, expected %b", got.conflict, want.conflict));
            if (got.done != want.done)
                flag_error($sformatf("pass_done %b, expected %b", got.done, want.done));
            if (got.ok != want.ok)
                flag_error($sformatf("pass_ok %b, expected %b", got.ok, want.ok));
            if (got.changed != want.changed)
                flag_error($sformatf("map_changed %b, expected %b", got.changed, want.changed));
            if (got.gen != want.gen)
                flag_error($sformatf("generation %0d, expected %0d", got.gen, want.gen));
            if (got.epoch != want.epoch)
                flag_error($sformatf("epoch %0d, expected %0d", got.epoch, want.epoch));
        end
    endtask

    // Driver: predict on acceptance, then load the next cell after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) merge_q.push_back(merge_cell(cur_txn));
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (cell_q.size() != 0) begin
                    cur_txn <= cell_q.pop_front();
                    i_valid <= 1'b1;
                    tx_gap  <= pick_gap(tx_burst);
                    if ($urandom_range(0, 49) == 0) tx_burst <= !tx_burst;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction and stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (o_valid && i_ready) check_merge();
            if (rx_stall > 0) begin
                i_ready  <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                i_ready  <= 1'b1;
                rx_stall <= pick_gap(rx_burst);
                if ($urandom_range(0, 49) == 0) rx_burst <= !rx_burst;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int target, p, w, h, kp, np;
        clear_map();
        for (int x = 0; x < GRID; x++) begin
            for (int y = 0; y < GRID; y++) begin
                maze_n[x][y]     = 1'($urandom);
                maze_e[x][y]     = 1'($urandom);
                robot_seen[x][y] = 1'($urandom);
            end
        end

        // Directed: conflict and abort, corners, lost sides, flipped walls, clears
        add_item(OP_CLEAR, 9, 9, 8'h5A, 8'hA5, 1, 1);
        add_item(OP_CELL, 0, 0, 8'h00, 8'hFF, 0, 0);
        add_item(OP_CELL, 1, 0, 8'hFF, 8'h00, 1, 0);
        add_item(OP_CELL, 2, 0, 8'h5A, 8'h3C, 1, 1);
        add_item(OP_CELL, 15, 15, 8'h0F, 8'h00, 1, 0);
        add_item(OP_CELL, 0, 15, 8'hF0, 8'h00, 1, 0);
        add_item(OP_CELL, 15, 0, 8'hFF, 8'hFF, 1, 1);
        add_item(OP_CELL, 15, 15, 8'hFF, 8'hFF, 0, 0);
        add_item(OP_CELL, 15, 0, 8'h0F, 8'hF0, 1, 1);
        add_item(OP_CELL, 15, 0, 8'h0F, 8'hF0, 1, 1);
        add_item(OP_CELL, 7, 7, 8'h55, 8'hAA, 1, 0);
        add_item(OP_CELL, 8, 7, 8'hAA, 8'h55, 0, 1);
        add_item(OP_CELL, 4, 4, 8'h00, 8'hFF, 0, 0);
        add_item(OP_CLEAR, 0, 0, 8'h00, 8'h00, 0, 0);
        add_item(OP_CELL, 4, 4, 8'h33, 8'hCC, 1, 1);
        add_item(OP_CELL, 5, 5, 8'hC3, 8'h00, 1, 0);
        add_item(OP_CLEAR, 15, 15, 8'hFF, 8'hFF, 1, 0);
        add_item(OP_CELL, 5, 5, 8'hC3, 8'h00, 1, 1);
        add_item(OP_CELL, 0, 0, 8'h00, 8'h00, 0, 1);

        // Random: mostly scan passes over the maze, some noise, edits and clears
        target = cell_q.size() + RANDOM_CELLS;
        while (cell_q.size() < target) begin
            p = $urandom_range(0, 99);
            if (p < 3) begin
                add_item(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                         8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (p < 13) begin
                repeat ($urandom_range(1, 6))
                    add_item(OP_CELL, $urandom_range(0, 15), $urandom_range(0, 15),
                             8'($urandom), 8'($urandom), 1'($urandom),
                             $urandom_range(0, 3) == 0);
            end else if (p < 18) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 0)
                        maze_n[$urandom_range(0, 15)][$urandom_range(0, 15)] = 1'($urandom);
                    else
                        maze_e[$urandom_range(0, 15)][$urandom_range(0, 15)] = 1'($urandom);
                end
            end else begin
                w  = $urandom_range(1, 5);
                h  = $urandom_range(1, 4);
                case ($urandom_range(0, 2))
                    0: kp = 30;
                    1: kp = 70;
                    default: kp = 100;
                endcase
                np = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                if ($urandom_range(0, 99) == 0)
                    add_pass(0, 0, GRID, GRID, kp, np);
                else
                    add_pass($urandom_range(0, GRID - w), $urandom_range(0, GRID - h),
                             w, h, kp, np);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all cells accepted, all results back, then a short tail
        while (cell_q.size() != 0 || i_valid) @(negedge i_clk);
        while (merge_q.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
